[rtl/command_line_tokenizer_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the command line tokenizer checker.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_UNIT_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication.
`define CLTOK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CLTOK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cltok_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltok_pkg
// Shared types and character constants of the command line tokenizer.
// ----------------------------------------------------------------------------
package cltok_pkg;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_TOKEN_END = 2'd1,
        KIND_CMD_END   = 2'd2
    } t_kind;

    // Characters with a special meaning.
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;

    // Separator after reset is the semicolon.
    localparam logic [7:0] SEP_RESET = 8'd59;

    // Most results one character can cause.
    localparam int GROUP_MAX = 3;

    // One result transaction, without its end-of-run mark.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        logic [4:0]  idx;
        logic        ovf;
        logic        drop;
    } t_result;

    // All results caused by one input character.
    typedef struct packed {
        t_result [GROUP_MAX-1:0] res;
        logic [1:0]              cnt;
    } t_group;

endpackage

[rtl/cltok_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltok_queue
// Short queue of result groups between the classifier and the output stage.
// ----------------------------------------------------------------------------
module cltok_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cltok_pkg::t_group i_group,
    output logic              o_full,
    output logic              o_valid,
    output cltok_pkg::t_group o_group,
    input  logic              i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cltok_pkg::t_group r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              wr_en;
    logic              rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_group = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (wr_en) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd_en) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_group;
        end
    end

endmodule

[rtl/cltok_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltok_front
// Accepts characters, tracks command and token state and builds the group of
// results that each character causes.
// ----------------------------------------------------------------------------
module cltok_front #(
    parameter int MAX_LINE = 256,
    parameter int MAX_ARGS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_in_char,
    input  logic              i_in_last,
    input  logic              i_cfg_valid,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_q_full,
    output logic              o_q_push,
    output cltok_pkg::t_group o_q_group
);

    localparam int LEN_W = $clog2(MAX_LINE + 1);
    localparam int TC_W  = $clog2(MAX_ARGS + 2);

    logic [7:0]       r_sep;
    logic             r_in_cmd, n_in_cmd;
    logic             r_quote, n_quote;
    logic             r_bs, n_bs;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_tact, n_tact;
    logic             r_tq, n_tq;
    logic             r_hv, n_hv;
    logic [7:0]       r_held, n_held;
    logic [TC_W-1:0]  r_tc, n_tc;
    logic             r_disc, n_disc;
    logic             r_aover, n_aover;

    logic              accept;
    logic              is_ws;
    logic              is_sep;
    logic              is_q;
    logic              copy;
    logic              done;
    logic              ovf_hit;
    logic              tok_start;
    logic [1:0]        cnt;
    cltok_pkg::t_group grp;

    function automatic cltok_pkg::t_result mk(cltok_pkg::t_kind kind, logic [7:0] ch,
                                              logic [4:0] idx, logic ovf, logic drop);
        cltok_pkg::t_result r;
        r.kind = kind;
        r.ch   = ch;
        r.idx  = idx;
        r.ovf  = ovf;
        r.drop = drop;
        return r;
    endfunction

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // Character classes.
    always_comb begin
        is_ws  = i_in_char inside {cltok_pkg::CHAR_SPACE, cltok_pkg::CHAR_TAB,
                                   cltok_pkg::CHAR_LF, cltok_pkg::CHAR_CR};
        is_sep = (i_in_char == r_sep);
        is_q   = (i_in_char == cltok_pkg::CHAR_DQUOTE) ||
                 (i_in_char == cltok_pkg::CHAR_SQUOTE);
    end

    // Next state and result group for the character on the input.
    always_comb begin
        n_in_cmd  = r_in_cmd;
        n_quote   = r_quote;
        n_bs      = r_bs;
        n_len     = r_len;
        n_tact    = r_tact;
        n_tq      = r_tq;
        n_hv      = r_hv;
        n_held    = r_held;
        n_tc      = r_tc;
        n_disc    = r_disc;
        n_aover   = r_aover;
        copy      = 1'b0;
        done      = 1'b0;
        ovf_hit   = 1'b0;
        tok_start = 1'b0;
        cnt       = 2'd0;
        grp       = '0;

        if (r_disc) begin
            // Everything up to the end of the string is thrown away.
            if (i_in_last) begin
                n_disc = 1'b0;
            end
        end else begin
            // A command starts at its first non-blank, non-separator character.
            if (!r_in_cmd && !(is_ws || is_sep)) begin
                n_in_cmd = 1'b1;
                n_quote  = 1'b0;
                n_bs     = 1'b0;
                n_len    = '0;
                n_tact   = 1'b0;
                n_tq     = 1'b0;
                n_hv     = 1'b0;
                n_held   = '0;
                n_tc     = '0;
                n_aover  = 1'b0;
            end

            if (n_in_cmd) begin
                copy = 1'b1;
                if (i_in_char == cltok_pkg::CHAR_CR) begin
                    copy = 1'b0;
                end else if (i_in_char == cltok_pkg::CHAR_BSLASH) begin
                    n_bs = 1'b1;
                    copy = 1'b0;
                end else begin
                    if (i_in_char == cltok_pkg::CHAR_LF) begin
                        done = !n_bs && !n_quote;
                        n_bs = 1'b0;
                    end else if (is_q) begin
                        n_quote = !n_quote;
                    end else if (is_sep) begin
                        done = !n_quote;
                    end
                    if (n_bs && i_in_char != cltok_pkg::CHAR_SPACE &&
                        i_in_char != cltok_pkg::CHAR_TAB) begin
                        n_bs = 1'b0;
                    end
                    if (done) begin
                        copy = 1'b0;
                    end
                end

                if (copy) begin
                    n_len = n_len + 1'b1;
                    if (n_len >= LEN_W'(MAX_LINE)) begin
                        // Line too long: close the command and drop the rest.
                        ovf_hit = 1'b1;
                        grp.res[cnt] = mk(cltok_pkg::KIND_CMD_END, 8'd0, 5'd0,
                                          1'b1, n_aover);
                        cnt      = cnt + 2'd1;
                        n_quote  = 1'b0;
                        n_bs     = 1'b0;
                        n_len    = '0;
                        n_tact   = 1'b0;
                        n_tq     = 1'b0;
                        n_hv     = 1'b0;
                        n_held   = '0;
                        n_tc     = '0;
                        n_aover  = 1'b0;
                        n_in_cmd = 1'b0;
                        if (!i_in_last) begin
                            n_disc = 1'b1;
                        end
                    end else if (!n_aover) begin
                        // Token building.
                        if (is_ws) begin
                            if (n_tact) begin
                                if (!n_quote) begin
                                    grp.res[cnt] = mk(cltok_pkg::KIND_TOKEN_END, 8'd0,
                                                      5'(n_tc), 1'b0, 1'b0);
                                    cnt    = cnt + 2'd1;
                                    n_tc   = n_tc + 1'b1;
                                    n_tact = 1'b0;
                                    n_tq   = 1'b0;
                                    n_hv   = 1'b0;
                                    n_held = '0;
                                end else if (n_tq) begin
                                    if (n_hv) begin
                                        grp.res[cnt] = mk(cltok_pkg::KIND_CHAR, n_held,
                                                          5'(n_tc), 1'b0, 1'b0);
                                        cnt = cnt + 2'd1;
                                    end
                                    n_held = i_in_char;
                                    n_hv   = 1'b1;
                                end else begin
                                    grp.res[cnt] = mk(cltok_pkg::KIND_CHAR, i_in_char,
                                                      5'(n_tc), 1'b0, 1'b0);
                                    cnt = cnt + 2'd1;
                                end
                            end
                        end else if (!n_tact && n_tc >= TC_W'(MAX_ARGS + 1)) begin
                            n_aover = 1'b1;
                        end else begin
                            if (!n_tact) begin
                                n_tact    = 1'b1;
                                n_tq      = is_q;
                                n_hv      = 1'b0;
                                tok_start = 1'b1;
                            end
                            // An opening quote starts the token and is not kept.
                            if (!(tok_start && is_q)) begin
                                if (n_tq) begin
                                    if (n_hv) begin
                                        grp.res[cnt] = mk(cltok_pkg::KIND_CHAR, n_held,
                                                          5'(n_tc), 1'b0, 1'b0);
                                        cnt = cnt + 2'd1;
                                    end
                                    n_held = i_in_char;
                                    n_hv   = 1'b1;
                                end else begin
                                    grp.res[cnt] = mk(cltok_pkg::KIND_CHAR, i_in_char,
                                                      5'(n_tc), 1'b0, 1'b0);
                                    cnt = cnt + 2'd1;
                                end
                            end
                        end
                    end
                end

                // End of command on an unquoted newline, separator or end of string.
                if (!ovf_hit && (done || i_in_last)) begin
                    if (n_tact && !n_aover) begin
                        grp.res[cnt] = mk(cltok_pkg::KIND_TOKEN_END, 8'd0,
                                          5'(n_tc), 1'b0, 1'b0);
                        cnt  = cnt + 2'd1;
                        n_tc = n_tc + 1'b1;
                    end
                    if (n_tc != '0) begin
                        grp.res[cnt] = mk(cltok_pkg::KIND_CMD_END, 8'd0, 5'd0,
                                          1'b0, n_aover);
                        cnt = cnt + 2'd1;
                    end
                    n_quote  = 1'b0;
                    n_bs     = 1'b0;
                    n_len    = '0;
                    n_tact   = 1'b0;
                    n_tq     = 1'b0;
                    n_hv     = 1'b0;
                    n_held   = '0;
                    n_tc     = '0;
                    n_aover  = 1'b0;
                    n_in_cmd = 1'b0;
                end
            end
        end
        grp.cnt = cnt;
    end

    assign o_q_push  = accept && (cnt != 2'd0);
    assign o_q_group = grp;

    // Separator register; the user must write it only while the block is idle, the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= cltok_pkg::SEP_RESET;
        end else if (i_cfg_valid) begin
            r_sep <= i_cfg_data;
        end
    end

    // Command and token state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cmd <= 1'b0;
            r_quote  <= 1'b0;
            r_bs     <= 1'b0;
            r_len    <= '0;
            r_tact   <= 1'b0;
            r_tq     <= 1'b0;
            r_hv     <= 1'b0;
            r_held   <= '0;
            r_tc     <= '0;
            r_disc   <= 1'b0;
            r_aover  <= 1'b0;
        end else if (accept) begin
            r_in_cmd <= n_in_cmd;
            r_quote  <= n_quote;
            r_bs     <= n_bs;
            r_len    <= n_len;
            r_tact   <= n_tact;
            r_tq     <= n_tq;
            r_hv     <= n_hv;
            r_held   <= n_held;
            r_tc     <= n_tc;
            r_disc   <= n_disc;
            r_aover  <= n_aover;
        end
    end

endmodule

[rtl/cltok_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltok_back
// Takes result groups from the queue and presents them one result at a time
// in an output register.
// ----------------------------------------------------------------------------
module cltok_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  cltok_pkg::t_group  i_q_group,
    output logic               o_q_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output cltok_pkg::t_result o_result,
    output logic               o_last
);

    logic               r_valid, n_valid;
    logic [1:0]         r_sub, n_sub;
    cltok_pkg::t_result r_out, n_out;
    logic               r_last, n_last;
    logic               take;

    assign take = r_valid && i_pop;

    // Load the next result whenever the output register is free or drained.
    always_comb begin
        n_valid = r_valid;
        n_sub   = r_sub;
        n_out   = r_out;
        n_last  = r_last;
        o_q_pop = 1'b0;
        if (i_q_valid && (!r_valid || take)) begin
            n_valid = 1'b1;
            n_out   = i_q_group.res[r_sub];
            if (r_sub == i_q_group.cnt - 2'd1) begin
                n_last  = 1'b1;
                n_sub   = 2'd0;
                o_q_pop = 1'b1;
            end else begin
                n_last = 1'b0;
                n_sub  = r_sub + 2'd1;
            end
        end else if (take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_last <= n_last;
    end

    assign o_empty  = !r_valid;
    assign o_result = r_out;
    assign o_last   = r_last;

endmodule

[rtl/command_line_tokenizer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_tokenizer_unit
// Splits a character stream into commands and tokens, shell style.
// ----------------------------------------------------------------------------
// Input channel: a character and its end-of-string flag are taken on a clock
// edge with push high and full low. Result channel: while empty is low the
// oldest result is on the o_ ports; pop high takes it at the clock edge.
// Each result is a token character, an end of token or an end of command;
// o_last_of_run marks the last result caused by one input character.
// Configuration: the user must write the separator through the cfg channel
// (always ready) only while no work is in flight; the block does not
// enforce this. Reset sets it to semicolon. The first result of a character
// is registered in the group queue, then in the output register.
// Throughput: one character per cycle as long as each causes at most one
// result and pop stays high; the output register delivers one result per
// cycle while pop is high, so a character causing k results holds the output
// until all k are taken. The group queue of QUEUE_DEPTH entries lets input
// run on while results wait. When the receiver stalls, the queue fills and
// full rises; nothing is lost. Reset (synchronous, active low) clears all
// command state, empties the queue and the output register.
// ----------------------------------------------------------------------------
module command_line_tokenizer_unit #(
    parameter int MAX_LINE    = 256,
    parameter int MAX_ARGS    = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_char,
    output logic [4:0] o_token_index,
    output logic       o_overflow,
    output logic       o_args_dropped,
    output logic       o_last_of_run,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_separator_char
);

    logic               fr_ready;
    logic               q_push;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    cltok_pkg::t_group  fr_group;
    cltok_pkg::t_group  q_group;
    cltok_pkg::t_result res;

    assign o_cfg_ready = 1'b1;
    assign full        = !fr_ready;

    // Classifier and command state.
    cltok_front #(
        .MAX_LINE (MAX_LINE),
        .MAX_ARGS (MAX_ARGS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (push),
        .o_in_ready  (fr_ready),
        .i_in_char   (i_in_char),
        .i_in_last   (i_in_last),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_separator_char),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_group   (fr_group)
    );

    // Decoupling queue.
    cltok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_group (fr_group),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_group (q_group),
        .i_pop   (q_pop)
    );

    // Result serializer.
    cltok_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_group (q_group),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (res),
        .o_last    (o_last_of_run)
    );

    assign o_out_kind     = res.kind;
    assign o_out_char     = res.ch;
    assign o_token_index  = res.idx;
    assign o_overflow     = res.ovf;
    assign o_args_dropped = res.drop;

endmodule

[rtl/cltok_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltok_checker
// Port-level checks of the command line tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "command_line_tokenizer_unit_macros.svh"

module cltok_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_empty,
    input logic       i_pop,
    input logic [1:0] i_out_kind,
    input logic [7:0] i_out_char,
    input logic [4:0] i_token_index,
    input logic       i_overflow,
    input logic       i_args_dropped,
    input logic       i_last_of_run
);

    // Nothing is shown right after reset.
    `CLTOK_ASSERT_NOW(a_empty_after_reset, $rose(i_rst_n), i_empty, "result shown after reset")

    // Only character results carry a character.
    `CLTOK_ASSERT_NOW(a_char_only_kind0, !i_empty && i_out_kind != cltok_pkg::KIND_CHAR, i_out_char == 8'd0 && i_overflow == 1'b0 || i_out_kind == cltok_pkg::KIND_CMD_END && i_out_char == 8'd0, "stray payload on non-character result")

    // Command flags and the token index belong to the right kinds.
    `CLTOK_ASSERT_NOW(a_cmd_end_fields, !i_empty && (i_overflow || i_args_dropped), i_out_kind == cltok_pkg::KIND_CMD_END && i_token_index == 5'd0 && i_last_of_run, "command flags on wrong result")

    // A held result stays put.
    `CLTOK_ASSERT_NEXT(a_hold_on_stall, !i_empty && !i_pop, !i_empty && $stable(i_out_kind) && $stable(i_out_char) && $stable(i_token_index) && $stable(i_last_of_run), "result changed while stalled")

endmodule

bind command_line_tokenizer_unit cltok_checker u_cltok_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_empty        (empty),
    .i_pop          (pop),
    .i_out_kind     (o_out_kind),
    .i_out_char     (o_out_char),
    .i_token_index  (o_token_index),
    .i_overflow     (o_overflow),
    .i_args_dropped (o_args_dropped),
    .i_last_of_run  (o_last_of_run)
);

[test/command_line_tokenizer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_tokenizer_unit_tb
// Self-checking bench for the shell-style command line tokenizer. Characters
// go in through the push/full queue port and results come out through the
// empty/pop port. A behavioral tokenizer inside the bench predicts the
// results of every accepted character. A checker process compares each
// popped result field by field against the oldest prediction. The tests
// cover basic parsing, the argument limit, line overflow and separator
// settings. They also cover a long receiver hold-off that backs up the input,
// and random command streams mixed with noise.
// ----------------------------------------------------------------------------
module command_line_tokenizer_unit_tb;

    localparam int LINE_LIMIT   = 256;
    localparam int ARG_LIMIT    = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_MAX   = 10;
    localparam int RANDOM_ITEMS = 32;

    // One result transaction as the tokenizer presents it.
    typedef struct packed {
        cltok_pkg::t_kind kind;
        logic [7:0]       ch;
        logic [4:0]       idx;
        logic             ovf;
        logic             drop;
        logic             last;
    } t_token_event;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_in_char;
    logic       i_in_last;
    logic       empty;
    logic       pop;
    logic [1:0] o_out_kind;
    logic [7:0] o_out_char;
    logic [4:0] o_token_index;
    logic       o_overflow;
    logic       o_args_dropped;
    logic       o_last_of_run;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_separator_char;

    // Predicted results, oldest first, and the results of the current character.
    t_token_event token_events[$];
    t_token_event char_events[$];

    // Tokenizer state as the bench tracks it.
    logic [7:0] sep_reg;
    logic       st_in_cmd;
    logic       st_quote;
    logic       st_bslash;
    int         st_len;
    logic       st_tok_active;
    logic       st_tok_quoted;
    logic       st_held_valid;
    logic [7:0] st_held_char;
    int         st_tok_count;
    logic       st_discard;
    logic       st_args_over;

    // Run bookkeeping.
    int   err_count;
    int   chars_sent;
    int   results_seen;
    int   cmd_ends;
    int   overflows_seen;
    int   drops_seen;
    int   full_cycles;
    int   sep_writes;
    int   cycle_count;
    logic no_idle;
    logic hold_req;
    logic rx_hold;

    command_line_tokenizer_unit #(
        .MAX_LINE(LINE_LIMIT),
        .MAX_ARGS(ARG_LIMIT)
    ) u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_in_char           (i_in_char),
        .i_in_last           (i_in_last),
        .empty               (empty),
        .pop                 (pop),
        .o_out_kind          (o_out_kind),
        .o_out_char          (o_out_char),
        .o_token_index       (o_token_index),
        .o_overflow          (o_overflow),
        .o_args_dropped      (o_args_dropped),
        .o_last_of_run       (o_last_of_run),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_separator_char(i_cfg_separator_char)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Guard against a hung run.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles, %0d results outstanding.",
                         cycle_count, token_events.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Behavioral tokenizer
    // ------------------------------------------------------------------------

    function automatic void note_result(cltok_pkg::t_kind kind, logic [7:0] ch, int idx,
                                        logic ovf, logic drop);
        t_token_event e;
        // One character never causes more than a group of results.
        if (char_events.size() < cltok_pkg::GROUP_MAX) begin
            e.kind = kind;
            e.ch   = ch;
            e.idx  = idx[4:0];
            e.ovf  = ovf;
            e.drop = drop;
            e.last = 1'b0;
            char_events.push_back(e);
        end
    endfunction

    function automatic void clear_command();
        st_quote      = 1'b0;
        st_bslash     = 1'b0;
        st_len        = 0;
        st_tok_active = 1'b0;
        st_tok_quoted = 1'b0;
        st_held_valid = 1'b0;
        st_held_char  = 8'h00;
        st_tok_count  = 0;
        st_args_over  = 1'b0;
    endfunction

    function automatic void reset_tokenizer();
        sep_reg    = cltok_pkg::SEP_RESET;
        st_in_cmd  = 1'b0;
        st_discard = 1'b0;
        clear_command();
    endfunction

    function automatic void close_token();
        note_result(cltok_pkg::KIND_TOKEN_END, 8'h00, st_tok_count, 1'b0, 1'b0);
        st_tok_count++;
        st_tok_active = 1'b0;
        st_tok_quoted = 1'b0;
        st_held_valid = 1'b0;
        st_held_char  = 8'h00;
    endfunction

    // A quoted token holds back one character so that its closing quote is lost.
    function automatic void append_char(logic [7:0] c);
        if (st_tok_quoted) begin
            if (st_held_valid)
                note_result(cltok_pkg::KIND_CHAR, st_held_char, st_tok_count, 1'b0, 1'b0);
            st_held_char  = c;
            st_held_valid = 1'b1;
        end else begin
            note_result(cltok_pkg::KIND_CHAR, c, st_tok_count, 1'b0, 1'b0);
        end
    endfunction

    function automatic void feed_token(logic [7:0] c);
        logic is_q;
        logic is_ws;
        is_q  = (c == cltok_pkg::CHAR_DQUOTE) || (c == cltok_pkg::CHAR_SQUOTE);
        is_ws = (c == cltok_pkg::CHAR_SPACE) || (c == cltok_pkg::CHAR_TAB) ||
                (c == cltok_pkg::CHAR_LF) || (c == cltok_pkg::CHAR_CR);
        if (st_args_over)
            return;
        if (is_ws) begin
            if (st_tok_active) begin
                if (!st_quote)
                    close_token();
                else
                    append_char(c);
            end
            return;
        end
        if (!st_tok_active) begin
            if (st_tok_count >= ARG_LIMIT + 1) begin
                st_args_over = 1'b1;
                return;
            end
            st_tok_active = 1'b1;
            st_tok_quoted = is_q;
            st_held_valid = 1'b0;
            if (is_q)
                return;
        end
        append_char(c);
    endfunction

    function automatic void close_command();
        if (st_tok_active && !st_args_over)
            close_token();
        if (st_tok_count > 0)
            note_result(cltok_pkg::KIND_CMD_END, 8'h00, 0, 1'b0, st_args_over);
        clear_command();
        st_in_cmd = 1'b0;
    endfunction

    // Predicts the results of one accepted character and queues them.
    function automatic void parse_char(logic [7:0] c, logic last);
        logic copy;
        logic done;
        logic overflowed;
        copy       = 1'b1;
        done       = 1'b0;
        overflowed = 1'b0;
        char_events.delete();
        if (st_discard) begin
            // Everything up to the end of the string is thrown away.
            if (last)
                st_discard = 1'b0;
        end else begin
            if (!st_in_cmd) begin
                if (!(c == cltok_pkg::CHAR_SPACE || c == cltok_pkg::CHAR_TAB ||
                      c == cltok_pkg::CHAR_LF || c == cltok_pkg::CHAR_CR ||
                      c == sep_reg)) begin
                    st_in_cmd = 1'b1;
                    clear_command();
                end
            end
            if (st_in_cmd) begin
                if (c == cltok_pkg::CHAR_CR) begin
                    copy = 1'b0;
                end else if (c == cltok_pkg::CHAR_BSLASH) begin
                    st_bslash = 1'b1;
                    copy      = 1'b0;
                end else begin
                    if (c == cltok_pkg::CHAR_LF) begin
                        done      = !st_bslash && !st_quote;
                        st_bslash = 1'b0;
                    end else if (c == cltok_pkg::CHAR_DQUOTE ||
                                 c == cltok_pkg::CHAR_SQUOTE) begin
                        st_quote = !st_quote;
                    end else if (c == sep_reg) begin
                        done = !st_quote;
                    end
                    if (st_bslash && c != cltok_pkg::CHAR_SPACE &&
                        c != cltok_pkg::CHAR_TAB)
                        st_bslash = 1'b0;
                    if (done)
                        copy = 1'b0;
                end
                if (copy) begin
                    st_len++;
                    if (st_len >= LINE_LIMIT) begin
                        // Line too long: flag it and drop the rest of the string.
                        note_result(cltok_pkg::KIND_CMD_END, 8'h00, 0, 1'b1, st_args_over);
                        clear_command();
                        st_in_cmd  = 1'b0;
                        overflowed = 1'b1;
                        if (!last)
                            st_discard = 1'b1;
                    end else begin
                        feed_token(c);
                    end
                end
                if (!overflowed && (done || last))
                    close_command();
            end
        end
        if (char_events.size() > 0)
            char_events[char_events.size() - 1].last = 1'b1;
        foreach (char_events[k])
            token_events.push_back(char_events[k]);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Printable character with no special meaning under the current separator.
    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        c = 8'($urandom_range(8'h21, 8'h7E));
        while (c == cltok_pkg::CHAR_DQUOTE || c == cltok_pkg::CHAR_SQUOTE ||
               c == cltok_pkg::CHAR_BSLASH || c == sep_reg)
            c = 8'($urandom_range(8'h21, 8'h7E));
        return c;
    endfunction

    // Offers one character and returns once the tokenizer has taken it.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_char <= c;
        i_in_last <= last;
        @(posedge i_clk);
        while (full) begin
            full_cycles++;
            @(posedge i_clk);
        end
        chars_sent++;
        parse_char(c, last);
    endtask

    task automatic send_text(input string s, input logic last);
        for (int k = 0; k < s.len(); k++)
            send_char(s[k], last && (k == s.len() - 1));
    endtask

    // Stops input and lets every predicted result drain, plus a margin for
    // characters that cause no result.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (token_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_separator(input logic [7:0] value);
        wait_idle();
        i_cfg_valid          <= 1'b1;
        i_cfg_separator_char <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sep_reg = value;
        sep_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // One well-formed command with random words, quotes and continuations.
    task automatic send_random_command();
        int         ntok;
        int         len;
        int         pick;
        logic [7:0] q;
        ntok = $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0)
            send_char(cltok_pkg::CHAR_SPACE, 1'b0);
        for (int t = 0; t < ntok; t++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                len = $urandom_range(1, 6);
                repeat (len) send_char(pick_plain(), 1'b0);
            end else if (pick < 9) begin
                q = $urandom_range(0, 1) ? cltok_pkg::CHAR_DQUOTE : cltok_pkg::CHAR_SQUOTE;
                send_char(q, 1'b0);
                len = $urandom_range(0, 4);
                repeat (len)
                    send_char(($urandom_range(0, 3) == 0) ? cltok_pkg::CHAR_SPACE
                                                          : pick_plain(), 1'b0);
                send_char(q, 1'b0);
            end else begin
                send_char(cltok_pkg::CHAR_BSLASH, 1'b0);
                if ($urandom_range(0, 1) == 0)
                    send_char(cltok_pkg::CHAR_TAB, 1'b0);
                send_char(cltok_pkg::CHAR_LF, 1'b0);
            end
            if (t < ntok - 1)
                send_char(($urandom_range(0, 4) == 0) ? cltok_pkg::CHAR_TAB
                                                      : cltok_pkg::CHAR_SPACE, 1'b0);
        end
        case ($urandom_range(0, 3))
            0: send_char(sep_reg, 1'b0);
            1: send_char(cltok_pkg::CHAR_LF, 1'b0);
            2: begin
                send_char(cltok_pkg::CHAR_CR, 1'b0);
                send_char(cltok_pkg::CHAR_LF, 1'b0);
            end
            default: send_char(cltok_pkg::CHAR_LF, 1'b1);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Skipped blanks, quoting, continuation, byte extremes, empty command and
    // a lone quote.
    task automatic test_basic_parsing();
        send_text(" ;a 'b c'\\ \n\"\";", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(cltok_pkg::CHAR_CR, 1'b0);
        send_char(cltok_pkg::CHAR_SQUOTE, 1'b1);
        send_char(cltok_pkg::CHAR_BSLASH, 1'b0);
        send_char(cltok_pkg::CHAR_CR, 1'b1);
        send_char(cltok_pkg::CHAR_SQUOTE, 1'b1);
    endtask

    // More tokens than the argument limit allows.
    task automatic test_arg_limit();
        for (int k = 0; k < ARG_LIMIT + 2; k++) begin
            send_char(8'(8'h61 + k), 1'b0);
            send_char(cltok_pkg::CHAR_SPACE, 1'b0);
        end
        send_char(cltok_pkg::CHAR_LF, 1'b0);
    endtask

    // A line past the length limit, with more tokens than the argument limit,
    // whose tail is discarded up to the end of the string, then a normal
    // command to show recovery.
    task automatic test_line_overflow();
        for (int k = 0; k < LINE_LIMIT + 2; k++)
            send_char((k % 7 == 6) ? cltok_pkg::CHAR_SPACE : 8'(8'h61 + k % 26),
                      k == LINE_LIMIT + 1);
        send_text("ok\n", 1'b0);
    endtask

    // Separator register at its extremes and at characters with other meanings.
    task automatic test_separator_settings();
        write_separator(8'h00);
        send_text("ab", 1'b0);
        send_char(8'h00, 1'b0);
        send_text(" c d", 1'b0);
        send_char(8'h00, 1'b0);
        write_separator(8'hFF);
        send_text("x 'y", 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("'", 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'hFF, 1'b1);
        write_separator(cltok_pkg::CHAR_LF);
        send_text("p q\n", 1'b0);
        write_separator(cltok_pkg::CHAR_SPACE);
        send_text("  r s \n", 1'b0);
        write_separator(cltok_pkg::CHAR_DQUOTE);
        send_text("\"t\" u\n", 1'b0);
        write_separator(cltok_pkg::SEP_RESET);
    endtask

    // The receiver holds off while characters keep coming, so the input stalls.
    task automatic test_backpressure();
        no_idle  = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < 16; k++)
            send_char((k % 9 == 8) ? cltok_pkg::CHAR_SPACE : 8'(8'h6B + k % 10), 1'b0);
        send_char(cltok_pkg::CHAR_LF, 1'b0);
        no_idle = 1'b0;
    endtask

    // Random command streams under several separators, with some noise.
    task automatic test_random_streams();
        logic [7:0] seps[4];
        int         target;
        int         burst;
        seps[0] = cltok_pkg::SEP_RESET;
        seps[1] = 8'h7C;
        seps[2] = 8'($urandom_range(0, 255));
        seps[3] = 8'h26;
        for (int ph = 0; ph < 4; ph++) begin
            write_separator(seps[ph]);
            no_idle = (ph == 1);
            target  = chars_sent + RANDOM_ITEMS / 4;
            while (chars_sent < target) begin
                if ($urandom_range(0, 99) < 15) begin
                    burst = $urandom_range(1, 5);
                    for (int k = 0; k < burst; k++)
                        send_char(8'($urandom_range(0, 255)),
                                  (k == burst - 1) ? 1'($urandom_range(0, 1)) : 1'b0);
                end else begin
                    send_random_command();
                end
            end
            no_idle = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random pops, an external hold-off, and result checking
    // ------------------------------------------------------------------------

    task automatic log_failure(input string what, input t_token_event exp_ev,
                               input t_token_event act_ev);
        if (err_count < REPORT_MAX) begin
            $write("Error at cycle %0d: %s; expected kind=%0d char=%02h idx=%0d ",
                   cycle_count, what, exp_ev.kind, exp_ev.ch, exp_ev.idx);
            $write("ovf=%0b drop=%0b last=%0b, ", exp_ev.ovf, exp_ev.drop, exp_ev.last);
            $write("got kind=%0d char=%02h idx=%0d ", act_ev.kind, act_ev.ch, act_ev.idx);
            $display("ovf=%0b drop=%0b last=%0b", act_ev.ovf, act_ev.drop, act_ev.last);
        end
        err_count++;
    endtask

    // Long hold-off of the receiver, timed here once a test asks for it.
    initial begin
        rx_hold <= 1'b0;
        forever begin
            wait (hold_req);
            hold_req = 1'b0;
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    initial begin
        t_token_event act_ev;
        t_token_event exp_ev;
        int           stall;
        int           r;
        stall = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            // A result transaction completes at this edge.
            if (i_rst_n && pop && !empty) begin
                act_ev.kind = cltok_pkg::t_kind'(o_out_kind);
                act_ev.ch   = o_out_char;
                act_ev.idx  = o_token_index;
                act_ev.ovf  = o_overflow;
                act_ev.drop = o_args_dropped;
                act_ev.last = o_last_of_run;
                results_seen++;
                if (token_events.size() == 0) begin
                    exp_ev = '0;
                    log_failure("result with nothing predicted", exp_ev, act_ev);
                end else begin
                    exp_ev = token_events.pop_front();
                    if (act_ev !== exp_ev)
                        log_failure("result mismatch", exp_ev, act_ev);
                    if (exp_ev.kind == cltok_pkg::KIND_CMD_END) begin
                        cmd_ends++;
                        if (exp_ev.ovf)
                            overflows_seen++;
                        if (exp_ev.drop)
                            drops_seen++;
                    end
                end
            end
            // Decide whether to take a result at the next edge.
            if (stall > 0) begin
                stall--;
            end else if (!no_idle) begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    stall = $urandom_range(1, 3);
                else if (r < 23)
                    stall = $urandom_range(10, 40);
            end
            pop <= i_rst_n && !rx_hold && (stall == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        err_count      = 0;
        chars_sent     = 0;
        results_seen   = 0;
        cmd_ends       = 0;
        overflows_seen = 0;
        drops_seen     = 0;
        full_cycles    = 0;
        sep_writes     = 0;
        no_idle        = 1'b0;
        hold_req       = 1'b0;
        reset_tokenizer();
        i_rst_n              <= 1'b0;
        push                 <= 1'b0;
        i_in_char            <= 8'h00;
        i_in_last            <= 1'b0;
        i_cfg_valid          <= 1'b0;
        i_cfg_separator_char <= 8'h00;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_parsing();
        test_arg_limit();
        test_line_overflow();
        test_separator_settings();
        test_backpressure();
        test_random_streams();

        // Let the last results drain, then allow for late extras.
        wait_idle();
        repeat (4 * SETTLE) @(posedge i_clk);
        err_count += token_events.size();

        $write("Run covered %0d characters and %0d results, %0d command ends ",
               chars_sent, results_seen, cmd_ends);
        $display("(%0d overflowed, %0d with dropped arguments).",
                 overflows_seen, drops_seen);
        $write("Separator written %0d times; input stalled by a full queue ", sep_writes);
        $display("for %0d cycles; %0d errors.", full_cycles, err_count);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
